// ===== sv/tcdp_pkg.sv =====
// Shared constants and controller/datapath interface types for the trellis decode dot product.
package tcdp_pkg;

	localparam logic [3:0]  BITS_RESET = 4'd4;
	localparam logic [31:0] HASH_MUL   = 32'd89226354;
	localparam logic [31:0] HASH_ADD   = 32'd64248484;
	localparam logic [31:0] HASH_MASK  = 32'h8fff8fff;
	localparam logic [31:0] HASH_XOR   = 32'h3b603b60;
	localparam logic [31:0] FP32_QNAN  = 32'hffc00000;
	localparam logic [31:0] FP32_QBIT  = 32'h00400000;

	// One step enable per datapath stage.
	typedef struct packed {
		logic capture;
		logic step_code;
		logic step_hash;
		logic step_wgt;
		logic step_mul;
		logic step_align;
		logic step_add;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} status_t;

endpackage

// ===== sv/tcdp_ctrl.sv =====
// Controller that steps one item through the decode and accumulate datapath.
module tcdp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tcdp_pkg::status_t status,
	output tcdp_pkg::cmd_t    cmd,
	output logic              in_stall
);
	import tcdp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CODE,
		ST_HASH,
		ST_WGT,
		ST_MUL,
		ST_ALIGN,
		ST_ADD,
		ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_q <= ST_CODE;
				end
			end
			ST_CODE:  state_q <= ST_HASH;
			ST_HASH:  state_q <= ST_WGT;
			ST_WGT:   state_q <= ST_MUL;
			ST_MUL:   state_q <= ST_ALIGN;
			ST_ALIGN: state_q <= ST_ADD;
			ST_ADD: begin
				state_q <= status.last ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					state_q <= ST_IDLE;
				end
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && in_valid;
		cmd.step_code  = (state_q == ST_CODE);
		cmd.step_hash  = (state_q == ST_HASH);
		cmd.step_wgt   = (state_q == ST_WGT);
		cmd.step_mul   = (state_q == ST_MUL);
		cmd.step_align = (state_q == ST_ALIGN);
		cmd.step_add   = (state_q == ST_ADD);
		cmd.out_load   = (state_q == ST_OUT) && status.out_free;
	end

endmodule

// ===== sv/tcdp_dpath.sv =====
// Datapath: code extraction, codebook decode, fp32 multiply-accumulate and fp16 output.
module tcdp_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  tcdp_pkg::cmd_t    cmd,
	output tcdp_pkg::status_t status,
	input  logic [3:0]        bits,
	input  logic [15:0]       activation,
	input  logic [31:0]       word_first,
	input  logic [31:0]       word_second,
	input  logic [3:0]        tile_row,
	input  logic [3:0]        tile_col,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       dot_sum
);
	import tcdp_pkg::*;

	function automatic logic [15:0] f32_to_f16(input logic [31:0] f);
		logic              s;
		logic [7:0]        ex;
		logic [22:0]       man;
		logic signed [9:0] e;
		logic signed [9:0] shv;
		logic [47:0]       ext;
		logic [14:0]       h;
		logic              inc;
		s   = f[31];
		ex  = f[30:23];
		man = f[22:0];
		e   = $signed({2'b00, ex}) - 10'sd112;
		shv = 10'sd14 - e;
		h   = '0;
		inc = 1'b0;
		ext = '0;
		if (ex == 8'hff) begin
			h = (man == 23'd0) ? 15'h7c00 : {5'h1f, 1'b1, man[21:13]};
		end else if (e >= 10'sd31) begin
			h = 15'h7c00;
		end else if (e <= 10'sd0) begin
			if (e >= -10'sd10) begin
				ext = {1'b1, man, 24'd0} >> shv[4:0];
				h   = ext[38:24];
				inc = ext[23] & ((|ext[22:0]) | ext[24]);
			end
		end else begin
			h   = {e[4:0], man[22:13]};
			inc = man[12] & ((|man[11:0]) | man[13]);
		end
		return {s, h + {14'd0, inc}};
	endfunction

	// Captured item
	logic [15:0] act_q;
	logic [63:0] merged_q;
	logic [3:0]  row_q;
	logic [3:0]  col_q;
	logic        last_q;
	// Stage results
	logic [15:0] code_q;
	logic [31:0] hash_q;
	logic [15:0] wgt_q;
	logic [31:0] prod_q;
	logic        al_spec_q;
	logic [31:0] al_spec_val_q;
	logic        al_sb_q;
	logic        al_ss_q;
	logic [7:0]  al_e_q;
	logic [26:0] al_mb_q;
	logic [26:0] al_ms_q;
	logic [31:0] acc_q;
	logic        out_valid_q;
	logic [15:0] dot_sum_q;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;
	assign status.last     = last_q;
	assign status.out_free = out_free;
	assign out_valid = out_valid_q;
	assign dot_sum   = dot_sum_q;

	// Code extraction: shift is minus (p+1)*bits modulo 32
	logic [7:0]  pos;
	logic [4:0]  pos_p1;
	logic [8:0]  pos_mul;
	logic [4:0]  code_sh;
	logic [63:0] code_shifted;
	always_comb begin
		pos          = {col_q[2:0], row_q[2:1], col_q[3], row_q[3], row_q[0]};
		pos_p1       = pos[4:0] + 5'd1;
		pos_mul      = {4'd0, pos_p1} * {5'd0, bits};
		code_sh      = 5'd0 - pos_mul[4:0];
		code_shifted = merged_q >> code_sh;
	end

	// Hash
	logic [47:0] hprod;
	logic [31:0] hsum;
	always_comb begin
		hprod = {32'd0, code_q} * {16'd0, HASH_MUL};
		hsum  = hprod[31:0] + HASH_ADD;
	end

	// Weight: sum of two fp16 halves, exponents 12..15, in units of 2^-13
	logic [14:0]        lo_mag;
	logic [14:0]        hi_mag;
	logic signed [16:0] lo_sv;
	logic signed [16:0] hi_sv;
	logic signed [16:0] wsum;
	logic               w_sign;
	logic [14:0]        w_mag;
	logic [3:0]         w_lead;
	logic [18:0]        w_norm;
	logic               w_inc;
	logic [4:0]         w_exp;
	logic [15:0]        w_res;
	always_comb begin
		lo_mag = {4'd0, 1'b1, hash_q[9:0]} << hash_q[11:10];
		hi_mag = {4'd0, 1'b1, hash_q[25:16]} << hash_q[27:26];
		lo_sv  = hash_q[15] ? -$signed({2'b00, lo_mag}) : $signed({2'b00, lo_mag});
		hi_sv  = hash_q[31] ? -$signed({2'b00, hi_mag}) : $signed({2'b00, hi_mag});
		wsum   = lo_sv + hi_sv;
		w_sign = wsum[16];
		w_mag  = w_sign ? 15'(-wsum) : wsum[14:0];
		w_lead = '0;
		for (int i = 0; i < 15; i++) begin
			if (w_mag[i]) begin
				w_lead = 4'(i);
			end
		end
		if (w_lead <= 4'd10) begin
			w_norm = {w_mag, 4'd0} << (4'd10 - w_lead);
		end else begin
			w_norm = {w_mag, 4'd0} >> (w_lead - 4'd10);
		end
		w_inc = w_norm[3] & ((|w_norm[2:0]) | w_norm[4]);
		w_exp = {1'b0, w_lead} + 5'd2;
		if (w_mag == 15'd0) begin
			w_res = 16'd0;
		end else begin
			w_res = {w_sign, {w_exp, w_norm[13:4]} + {14'd0, w_inc}};
		end
	end

	// Product: exact fp32 of fp16 activation times fp16 weight
	logic        a_nan;
	logic        a_inf;
	logic [10:0] a_m;
	logic [4:0]  a_e;
	logic        w_zero;
	logic [21:0] pm;
	logic [4:0]  p_lead;
	logic [21:0] p_norm;
	logic [8:0]  p_exp;
	logic        p_sign;
	logic [31:0] p_res;
	always_comb begin
		a_nan  = (act_q[14:10] == 5'h1f) && (act_q[9:0] != 10'd0);
		a_inf  = (act_q[14:10] == 5'h1f) && (act_q[9:0] == 10'd0);
		a_m    = {act_q[14:10] != 5'd0, act_q[9:0]};
		a_e    = (act_q[14:10] == 5'd0) ? 5'd1 : act_q[14:10];
		w_zero = (wgt_q[14:0] == 15'd0);
		p_sign = act_q[15] ^ wgt_q[15];
		pm     = {11'd0, a_m} * {11'd0, 1'b1, wgt_q[9:0]};
		p_lead = '0;
		for (int i = 0; i < 22; i++) begin
			if (pm[i]) begin
				p_lead = 5'(i);
			end
		end
		p_norm = pm << (5'd21 - p_lead);
		p_exp  = {4'd0, p_lead} + {4'd0, a_e} + {4'd0, wgt_q[14:10]} + 9'd77;
		if (a_nan) begin
			p_res = {act_q[15], 8'hff, 1'b1, act_q[8:0], 13'd0};
		end else if (a_inf) begin
			p_res = w_zero ? FP32_QNAN : {p_sign, 8'hff, 23'd0};
		end else if (w_zero || a_m == 11'd0) begin
			p_res = {p_sign, 31'd0};
		end else begin
			p_res = {p_sign, p_exp[7:0], p_norm[20:0], 2'b00};
		end
	end

	// Align: order by magnitude, shift the smaller mantissa with sticky
	logic        x_nan;
	logic        x_inf;
	logic        y_nan;
	logic        y_inf;
	logic        spec;
	logic [31:0] spec_val;
	logic [31:0] big;
	logic [31:0] sml;
	logic [7:0]  eb;
	logic [7:0]  es;
	logic [7:0]  ed;
	logic [4:0]  dsh;
	logic [53:0] sext;
	always_comb begin
		x_nan = (acc_q[30:23] == 8'hff) && (acc_q[22:0] != 23'd0);
		x_inf = (acc_q[30:23] == 8'hff) && (acc_q[22:0] == 23'd0);
		y_nan = (prod_q[30:23] == 8'hff) && (prod_q[22:0] != 23'd0);
		y_inf = (prod_q[30:23] == 8'hff) && (prod_q[22:0] == 23'd0);
		spec  = x_nan || x_inf || y_nan || y_inf;
		if (x_nan) begin
			spec_val = acc_q | FP32_QBIT;
		end else if (y_nan) begin
			spec_val = prod_q | FP32_QBIT;
		end else if (x_inf) begin
			spec_val = (y_inf && (acc_q[31] != prod_q[31])) ? FP32_QNAN : acc_q;
		end else begin
			spec_val = prod_q;
		end
		if (acc_q[30:0] >= prod_q[30:0]) begin
			big = acc_q;
			sml = prod_q;
		end else begin
			big = prod_q;
			sml = acc_q;
		end
		eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		ed   = eb - es;
		dsh  = (ed > 8'd27) ? 5'd27 : ed[4:0];
		sext = {sml[30:23] != 8'd0, sml[22:0], 3'd0, 27'd0} >> dsh;
	end

	// Add, normalize, round to nearest even
	logic        sub;
	logic [27:0] asum;
	logic [4:0]  a_lead;
	logic [4:0]  lsh;
	logic [7:0]  lim;
	logic [26:0] an;
	logic [8:0]  ae9;
	logic [7:0]  afield;
	logic        a_inc;
	logic [30:0] around;
	logic [31:0] add_res;
	always_comb begin
		sub    = al_sb_q ^ al_ss_q;
		asum   = sub ? ({1'b0, al_mb_q} - {1'b0, al_ms_q}) : ({1'b0, al_mb_q} + {1'b0, al_ms_q});
		a_lead = '0;
		for (int i = 0; i < 27; i++) begin
			if (asum[i]) begin
				a_lead = 5'(i);
			end
		end
		lim = al_e_q - 8'd1;
		lsh = 5'd26 - a_lead;
		if ({3'd0, lsh} > lim) begin
			lsh = lim[4:0];
		end
		if (asum[27]) begin
			an  = {asum[27:2], asum[1] | asum[0]};
			ae9 = {1'b0, al_e_q} + 9'd1;
		end else begin
			an  = asum[26:0] << lsh;
			ae9 = {1'b0, al_e_q} - {4'd0, lsh};
		end
		afield = an[26] ? ae9[7:0] : 8'd0;
		a_inc  = an[2] & (an[1] | an[0] | an[3]);
		around = {afield, an[25:3]} + {30'd0, a_inc};
		if (al_spec_q) begin
			add_res = al_spec_val_q;
		end else if (asum == 28'd0) begin
			add_res = {al_sb_q & ~sub, 31'd0};
		end else if (ae9 >= 9'd255) begin
			add_res = {al_sb_q, 8'hff, 23'd0};
		end else begin
			add_res = {al_sb_q, around};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= activation;
			merged_q <= {word_first, word_second};
			row_q    <= tile_row;
			col_q    <= tile_col;
			last_q   <= last;
		end
		if (cmd.step_code) begin
			code_q <= code_shifted[15:0];
		end
		if (cmd.step_hash) begin
			hash_q <= (hsum & HASH_MASK) ^ HASH_XOR;
		end
		if (cmd.step_wgt) begin
			wgt_q <= w_res;
		end
		if (cmd.step_mul) begin
			prod_q <= p_res;
		end
		if (cmd.step_align) begin
			al_spec_q     <= spec;
			al_spec_val_q <= spec_val;
			al_sb_q       <= big[31];
			al_ss_q       <= sml[31];
			al_e_q        <= eb;
			al_mb_q       <= {big[30:23] != 8'd0, big[22:0], 3'd0};
			al_ms_q       <= {sext[53:28], sext[27] | (|sext[26:0])};
		end
		if (cmd.out_load) begin
			dot_sum_q <= f32_to_f16(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				acc_q <= '0;
			end else if (cmd.step_add) begin
				acc_q <= add_res;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_steps_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath step enabled");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over a stalled result");

	a_clear_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (acc_q == 32'd0) && out_valid_q)
		else $error("accumulator not cleared after result");

	a_capture_then_code: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.step_code)
		else $error("captured item not processed");

endmodule

// ===== sv/trellis_code_decode_dot_product.sv =====
// Top level of the trellis code decode dot product block.
//
// Input channel (in_valid / in_stall): one weight position per item with its
// fp16 activation, the two tile code words holding its code, and last.
// An item is taken when in_valid is high and in_stall is low.
// Each item runs through capture, code extract, hash, weight decode,
// multiply, align and add steps of one shared datapath: the next item is
// taken only after the previous one has finished its add step (and its
// output load when it had last set), since the fp32 accumulate feeds
// back into the following item. On last, the accumulator is rounded to fp16
// and loaded into the output register (out_valid / out_stall) after the add
// step, and the accumulator returns to +0.
// A stalled result holds; the block keeps taking items and only waits when
// a further result finds the output register still full.
// Configuration (cfg_valid / cfg_ready) writes bits_per_weight; cfg_ready is
// always high and writes belong to idle periods. A value of 0 acts as 1.
// Reset clears the accumulator, drops out_valid and sets bits_per_weight to 4.
module trellis_code_decode_dot_product (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] activation,
	input  logic [31:0] word_first,
	input  logic [31:0] word_second,
	input  logic [3:0]  tile_row,
	input  logic [3:0]  tile_col,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] dot_sum
);
	import tcdp_pkg::*;

	logic [3:0] bits_q;
	logic [3:0] bits_eff;
	cmd_t       cmd;
	status_t    status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bits_q <= cfg_data;
		end
	end

	// zero bits per weight saturates to one
	assign bits_eff = (bits_q == 4'd0) ? 4'd1 : bits_q;

	tcdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	tcdp_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.bits        (bits_eff),
		.activation  (activation),
		.word_first  (word_first),
		.word_second (word_second),
		.tile_row    (tile_row),
		.tile_col    (tile_col),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.dot_sum     (dot_sum)
	);

endmodule

// ===== test/trellis_code_decode_dot_product_test.sv =====
// Testbench for the trellis code decode dot product block: directed table, then random items.
module trellis_code_decode_dot_product_test;
	import tcdp_pkg::*;

	typedef struct {
		logic [15:0] act;
		logic [31:0] first;
		logic [31:0] second;
		logic [3:0]  row;
		logic [3:0]  col;
		logic        lst;
		logic        typed;
		logic [15:0] sum;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] activation = 16'd0;
	logic [31:0] word_first = 32'd0;
	logic [31:0] word_second = 32'd0;
	logic [3:0]  tile_row = 4'd0;
	logic [3:0]  tile_col = 4'd0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] dot_sum;

	logic [15:0] expected_sums[$];
	logic [15:0] oldest_sum;
	logic [31:0] acc_bits;
	logic [3:0]  bits_setting;
	int          errors = 0;
	int          snd_pct = 16;
	int          rcv_pct = 63;

	directed_row_t directed[14] = '{
		'{16'h0000, 32'h0, 32'h0, 4'd0, 4'd0, 1'b1, 1'b1, 16'h0000},
		'{16'h8000, 32'hffffffff, 32'hffffffff, 4'd15, 4'd15, 1'b1, 1'b1, 16'h0000},
		'{16'h7e00, 32'h12345678, 32'h9abcdef0, 4'd3, 4'd9, 1'b1, 1'b1, 16'h7e00},
		'{16'h7bff, 32'hffffffff, 32'h0, 4'd0, 4'd15, 1'b0, 1'b0, 16'h0},
		'{16'hfbff, 32'h0, 32'hffffffff, 4'd15, 4'd0, 1'b0, 1'b0, 16'h0},
		'{16'h7bff, 32'ha5a5a5a5, 32'h5a5a5a5a, 4'd8, 4'd7, 1'b1, 1'b0, 16'h0},
		'{16'h0001, 32'hdeadbeef, 32'h01234567, 4'd1, 4'd1, 1'b0, 1'b0, 16'h0},
		'{16'h8001, 32'h0f0f0f0f, 32'hf0f0f0f0, 4'd14, 4'd2, 1'b0, 1'b0, 16'h0},
		'{16'h0400, 32'h00000001, 32'h80000000, 4'd5, 4'd12, 1'b1, 1'b0, 16'h0},
		'{16'h7c00, 32'h11111111, 32'h22222222, 4'd2, 4'd3, 1'b0, 1'b0, 16'h0},
		'{16'hfc00, 32'h33333333, 32'h44444444, 4'd9, 4'd11, 1'b1, 1'b0, 16'h0},
		'{16'h7c00, 32'h55555555, 32'h66666666, 4'd6, 4'd4, 1'b1, 1'b0, 16'h0},
		'{16'h7d00, 32'h77777777, 32'h88888888, 4'd10, 4'd13, 1'b1, 1'b0, 16'h0},
		'{16'h3c00, 32'hcafef00d, 32'h0badc0de, 4'd7, 4'd8, 1'b1, 1'b0, 16'h0}
	};

	trellis_code_decode_dot_product dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.activation(activation), .word_first(word_first), .word_second(word_second),
		.tile_row(tile_row), .tile_col(tile_col), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .dot_sum(dot_sum)
	);

	always #2 clk = ~clk;

	// fp16 as a signed integer in units of 2^-24
	function automatic logic signed [99:0] half_to_fixed(input logic [15:0] h);
		logic [99:0] u;
		if (h[14:10] == 5'd0)
			u = 100'(h[9:0]);
		else
			u = 100'({1'b1, h[9:0]}) << (h[14:10] - 1);
		return h[15] ? -$signed(u) : $signed(u);
	endfunction

	// finite fp32 as a signed integer in units of 2^-149
	function automatic logic signed [299:0] single_to_fixed(input logic [31:0] f);
		logic [299:0] u;
		if (f[30:23] == 8'd0)
			u = 300'(f[22:0]);
		else
			u = 300'({1'b1, f[22:0]}) << (f[30:23] - 1);
		return f[31] ? -$signed(u) : $signed(u);
	endfunction

	// round an exact value in units of 2^-149 to fp32, nearest even
	function automatic logic [31:0] fixed_to_single(input logic signed [299:0] v,
			input logic neg_zero);
		logic [299:0] mag, kept, rem, half;
		logic [63:0]  wide;
		logic         s;
		int           msb, sh;
		if (v == 0)
			return neg_zero ? 32'h80000000 : 32'h0;
		s = v < 0;
		mag = s ? -v : v;
		msb = 0;
		for (int i = 0; i < 300; i++)
			if (mag[i])
				msb = i;
		if (msb <= 23)
			return {s, mag[30:0]};
		sh = msb - 23;
		kept = mag >> sh;
		rem = mag & ((300'd1 << sh) - 300'd1);
		half = 300'd1 << (sh - 1);
		if (rem > half || (rem == half && kept[0]))
			kept = kept + 300'd1;
		// hidden bit carries into the exponent field
		wide = (64'(sh) << 23) + kept[63:0];
		if (wide >= 64'h7f800000)
			wide = 64'h7f800000;
		return {s, wide[30:0]};
	endfunction

	function automatic logic [15:0] single_to_half(input logic [31:0] f);
		logic [31:0] sgn, man, h, rem, halfway, m;
		int          e, shift;
		sgn = (f >> 16) & 32'h8000;
		man = f & 32'h7fffff;
		if (f[30:23] == 8'hff)
			return (man == 0) ? 16'(sgn | 32'h7c00) : 16'(sgn | 32'h7e00 | (man >> 13));
		e = int'(f[30:23]) - 112;
		if (e >= 31)
			return 16'(sgn | 32'h7c00);
		if (e <= 0) begin
			if (e < -10)
				return 16'(sgn);
			m = man | 32'h800000;
			shift = 14 - e;
			h = m >> shift;
			rem = m & ((32'd1 << shift) - 1);
			halfway = 32'd1 << (shift - 1);
			if (rem > halfway || (rem == halfway && h[0]))
				h = h + 1;
			return 16'(sgn | h);
		end
		h = (32'(e) << 10) | (man >> 13);
		rem = man & 32'h1fff;
		if (rem > 32'h1000 || (rem == 32'h1000 && h[0]))
			h = h + 1;
		return 16'(sgn | h);
	endfunction

	function automatic logic [15:0] weight_of_code(input logic [31:0] code);
		logic [31:0]         x;
		logic signed [299:0] s;
		x = code * HASH_MUL + HASH_ADD;
		x = (x & HASH_MASK) ^ HASH_XOR;
		s = half_to_fixed(x[15:0]) + half_to_fixed(x[31:16]);
		return single_to_half(fixed_to_single(s <<< 125, x[15] & x[31]));
	endfunction

	function automatic logic [31:0] tile_code(input logic [31:0] first, input logic [31:0] second,
			input logic [3:0] row, input logic [3:0] col, input logic [3:0] bits);
		logic [31:0] t, k, p, b0, i1, sh, nb;
		logic [63:0] merged;
		nb = (bits == 4'd0) ? 32'd1 : 32'(bits);
		t = 32'(col[2:0]) * 4 + 32'(row[2:0]) / 2;
		k = 32'(row[0]) + 2 * 32'(row[3]) + 4 * 32'(col[3]);
		p = t * 8 + k;
		b0 = p * nb + nb - 32'd16 + 32'd256 * nb;
		i1 = (b0 + 32'd15) / 32'd32;
		sh = (i1 + 1) * 32 - b0 - 32'd16;
		merged = {first, second};
		return 32'(merged >> sh[5:0]) & 32'hffff;
	endfunction

	// advance the accumulator by one product; returns 1 when a sum is due
	function automatic logic accumulate_product(input logic [15:0] act, input logic [31:0] first,
			input logic [31:0] second, input logic [3:0] row, input logic [3:0] col,
			input logic lst, output logic [15:0] sum);
		logic [15:0]         w;
		logic [31:0]         prod;
		logic signed [199:0] pa, pw, pp;
		logic                acc_nan, prod_nan, acc_inf, prod_inf;
		w = weight_of_code(tile_code(first, second, row, col, bits_setting));
		if (act[14:10] == 5'h1f && act[9:0] != 0)
			prod = {act[15], 8'hff, 1'b1, act[8:0], 13'd0};
		else if (act[14:10] == 5'h1f)
			// infinity times zero is the default NaN
			prod = (w[14:0] == 15'd0) ? FP32_QNAN : {act[15] ^ w[15], 31'h7f800000};
		else begin
			pa = half_to_fixed(act);
			pw = half_to_fixed(w);
			pp = pa * pw;
			prod = fixed_to_single(300'(pp) <<< 101, act[15] ^ w[15]);
		end
		acc_nan = acc_bits[30:23] == 8'hff && acc_bits[22:0] != 0;
		prod_nan = prod[30:23] == 8'hff && prod[22:0] != 0;
		acc_inf = acc_bits[30:0] == 31'h7f800000;
		prod_inf = prod[30:0] == 31'h7f800000;
		if (acc_nan)
			acc_bits = acc_bits;
		else if (prod_nan)
			acc_bits = prod;
		else if (acc_inf && prod_inf && acc_bits[31] != prod[31])
			acc_bits = FP32_QNAN;
		else if (acc_inf)
			acc_bits = acc_bits;
		else if (prod_inf)
			acc_bits = prod;
		else
			acc_bits = fixed_to_single(single_to_fixed(acc_bits) + single_to_fixed(prod),
				acc_bits[31] & prod[31]);
		sum = single_to_half(acc_bits);
		if (lst)
			acc_bits = 32'h0;
		return lst;
	endfunction

	task automatic send_item(input logic [15:0] act, input logic [31:0] first,
			input logic [31:0] second, input logic [3:0] row, input logic [3:0] col,
			input logic lst, input logic typed, input logic [15:0] typed_sum);
		logic [15:0] sum;
		if ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		activation <= act;
		word_first <= first;
		word_second <= second;
		tile_row <= row;
		tile_col <= col;
		last <= lst;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (accumulate_product(act, first, second, row, col, lst, sum))
			expected_sums = {expected_sums, (typed ? typed_sum : sum)};
	endtask

	// hold input until every sum is out and the pipeline has emptied
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_bits(input logic [3:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		bits_setting = v;
	endtask

	task automatic random_items(input int n);
		logic [15:0] act;
		int          left;
		left = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0)
				left = $urandom_range(1, 16);
			left--;
			if ($urandom_range(9) == 0)
				act = 16'($urandom);
			else
				act = {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
			send_item(act, $urandom, $urandom, 4'($urandom), 4'($urandom),
				(left == 0 || i == n - 1), 1'b0, 16'h0);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				$error("dot_sum unexpected result %h", dot_sum);
				errors++;
			end else begin
				oldest_sum = expected_sums.pop_front();
				if (dot_sum !== oldest_sum) begin
					$error("dot_sum expected %h actual %h", oldest_sum, dot_sum);
					errors++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < rcv_pct);
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [3:0] settings[7];
		acc_bits = 32'h0;
		bits_setting = BITS_RESET;
		settings = '{4'd4, 4'd1, 4'd8, 4'd0, 4'd15, 4'd0, 4'd0};
		for (int i = 5; i < 7; i++)
			settings[i] = 4'($urandom_range(0, 15));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_item(directed[i].act, directed[i].first, directed[i].second,
				directed[i].row, directed[i].col, directed[i].lst,
				directed[i].typed, directed[i].sum);
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 3) begin
				snd_pct = 63;
				rcv_pct = 16;
			end else if (ph == 5) begin
				snd_pct = 0;
				rcv_pct = 0;
			end
			if (ph != 0) begin
				drain();
				write_bits(settings[ph]);
			end
			random_items(148);
		end
		drain();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
